// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside of reset.
`define FCS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define FCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fat12fcs_pkg.sv =====
`timescale 1ns / 1ps

package fat12fcs_pkg;

  localparam int unsigned ENTRY_W = 12;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [ENTRY_W-1:0] WANTED_RESET = 12'd1;
  localparam logic [ENTRY_W-1:0] FREE_ENTRY   = 12'h000;

  typedef struct packed {
    logic [BYTE_W-1:0] table_byte;
    logic              end_of_table;
  } in_item_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] cluster_number;
    logic               has_cluster;
    logic               final_res;
  } out_item_t;

  typedef struct packed {
    logic      emit;
    out_item_t item;
  } scan_res_t;

endpackage

// ===== rtl/fat12fcs_unpack.sv =====
`timescale 1ns / 1ps

module fat12fcs_unpack (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  fat12fcs_pkg::in_item_t               in_item,
  input  logic [fat12fcs_pkg::ENTRY_W-1:0]     wanted_count,
  output fat12fcs_pkg::scan_res_t              res
);

  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  logic [1:0]                          byte_phase;
  logic [1:0]                          byte_phase_next;
  logic [fat12fcs_pkg::BYTE_W-1:0]     held_byte;
  logic [fat12fcs_pkg::BYTE_W-1:0]     held_byte_next;
  logic [fat12fcs_pkg::ENTRY_W-1:0]    entry_index;
  logic [fat12fcs_pkg::ENTRY_W-1:0]    entry_index_next;
  logic [fat12fcs_pkg::ENTRY_W-1:0]    found_count;
  logic [fat12fcs_pkg::ENTRY_W-1:0]    found_count_next;
  logic                                scan_done;
  logic                                scan_done_next;

  logic [fat12fcs_pkg::ENTRY_W-1:0]    entry;
  logic [fat12fcs_pkg::ENTRY_W-1:0]    found_inc;
  logic                                have_entry;
  logic                                hit;
  logic                                fin;

  assign found_inc = found_count + fat12fcs_pkg::ENTRY_W'(1);

  always_comb begin
    byte_phase_next  = byte_phase;
    held_byte_next   = held_byte;
    entry_index_next = entry_index;
    found_count_next = found_count;
    scan_done_next   = scan_done;
    entry            = fat12fcs_pkg::FREE_ENTRY;
    have_entry       = 1'b0;
    hit              = 1'b0;
    fin              = 1'b0;

    if (!scan_done) begin
      case (byte_phase)
        PHASE_SECOND: begin
          entry           = {in_item.table_byte[3:0], held_byte};
          have_entry      = 1'b1;
          held_byte_next  = in_item.table_byte;
          byte_phase_next = PHASE_THIRD;
        end
        PHASE_THIRD: begin
          entry           = {in_item.table_byte, held_byte[7:4]};
          have_entry      = 1'b1;
          held_byte_next  = '0;
          byte_phase_next = PHASE_FIRST;
        end
        default: begin
          held_byte_next  = in_item.table_byte;
          byte_phase_next = PHASE_SECOND;
        end
      endcase

      if (have_entry) begin
        if (entry == fat12fcs_pkg::FREE_ENTRY) begin
          hit              = 1'b1;
          found_count_next = found_inc;
          if (found_inc >= wanted_count) begin
            fin            = 1'b1;
            scan_done_next = 1'b1;
          end
        end
        entry_index_next = entry_index + fat12fcs_pkg::ENTRY_W'(1);
      end

      if (in_item.end_of_table) begin
        fin = 1'b1;
      end
    end

    // clear the scan at the end of the table
    if (in_item.end_of_table) begin
      byte_phase_next  = PHASE_FIRST;
      held_byte_next   = '0;
      entry_index_next = '0;
      found_count_next = '0;
      scan_done_next   = 1'b0;
    end
  end

  always_comb begin
    res.emit                = hit | fin;
    res.item.cluster_number = hit ? entry_index : '0;
    res.item.has_cluster    = hit;
    res.item.final_res      = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase  <= PHASE_FIRST;
      held_byte   <= '0;
      entry_index <= '0;
      found_count <= '0;
      scan_done   <= 1'b0;
    end else if (accept) begin
      byte_phase  <= byte_phase_next;
      held_byte   <= held_byte_next;
      entry_index <= entry_index_next;
      found_count <= found_count_next;
      scan_done   <= scan_done_next;
    end
  end

endmodule

// ===== rtl/fat12fcs_outreg.sv =====
`timescale 1ns / 1ps

module fat12fcs_outreg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  fat12fcs_pkg::out_item_t   load_item,
  output logic                      free,
  output logic                      out_valid,
  input  logic                      out_ready,
  output fat12fcs_pkg::out_item_t   out_data
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_item;
    end
  end

endmodule

// ===== rtl/fat12_free_cluster_scan_unit.sv =====
`timescale 1ns / 1ps
// A result appears on out_valid in the cycle after the table byte that produces it is accepted.
// Throughput: one table byte per cycle; in_ready drops only while the output
// register holds a result that is not taken.
// Reset (rst, synchronous): clears the scan state and out_valid (out_data is not reset) and
// sets wanted_count to 1.

module fat12_free_cluster_scan_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fat12fcs_pkg::ENTRY_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  fat12fcs_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output fat12fcs_pkg::out_item_t              out_data
);

  logic [fat12fcs_pkg::ENTRY_W-1:0] wanted_count;
  fat12fcs_pkg::scan_res_t          res;
  logic                             accept;
  logic                             free;

  assign cfg_ready = 1'b1;
  assign in_ready  = free;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_count <= fat12fcs_pkg::WANTED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      wanted_count <= cfg_data;
    end
  end

  fat12fcs_unpack u_unpack (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_item      (in_data),
    .wanted_count (wanted_count),
    .res          (res)
  );

  fat12fcs_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && res.emit),
    .load_item (res.item),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/fat12fcs_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fat12fcs_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input fat12fcs_pkg::out_item_t           out_data
);

  logic stalled;
  logic empty_out;

  assign stalled   = out_valid && !out_ready;
  assign empty_out = out_valid && !out_data.has_cluster;

  `FCS_ASSERT(a_out_hold, clk, rst, stalled |=> out_valid, "result dropped")
  `FCS_ASSERT(a_out_stable, clk, rst, stalled |=> $stable(out_data), "result changed in stall")
  `FCS_ASSERT(a_empty_zero, clk, rst, empty_out |-> out_data.cluster_number == '0, "stray cluster")
  `FCS_ASSERT(a_empty_final, clk, rst, empty_out |-> out_data.final_res, "empty not final")
  `FCS_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind fat12_free_cluster_scan_unit fat12fcs_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
